[hw/rtl/wbs_pkg.sv]
`timescale 1ns / 1ps

package wbs_pkg;

  // Item kinds carried in the low bits of the input word
  localparam logic [1:0] FUNC_WR_CHAR = 2'd0;
  localparam logic [1:0] FUNC_WR_LEN  = 2'd1;
  localparam logic [1:0] FUNC_TEXT    = 2'd2;

  // Field widths, fixed by the stream format
  localparam int FuncW = 2;
  localparam int SlotFieldW = 4;
  localparam int PosFieldW = 4;
  localparam int CharW = 8;
  localparam int LenW = 5;

  localparam int InDataW = 24;
  localparam int OutDataW = 8;

  // Dictionary write request from the input decode to the storage
  typedef struct packed {
    logic                  wr_char;
    logic                  wr_len;
    logic [SlotFieldW-1:0] slot;
    logic [PosFieldW-1:0]  pos;
    logic [CharW-1:0]      ch;
    logic [LenW-1:0]       len;
  } wbs_wr_t;

endpackage

[hw/rtl/wbs_dict.sv]
`timescale 1ns / 1ps

// Dictionary storage: one row per slot, one byte lane per character position,
// plus the slot lengths. One registered row read per cycle.
module wbs_dict import wbs_pkg::*; #(
  parameter int NUM_WORDS = 16,
  parameter int MAX_WORD_LEN = 16,
  localparam int SlotW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
  localparam int PosW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wbs_wr_t                            wr_i,
  input  logic [SlotW-1:0]                   rd_addr_i,
  output logic [MAX_WORD_LEN-1:0][CharW-1:0] rd_row_o,
  output logic [LenW-1:0]                    rd_len_o
);

  logic [MAX_WORD_LEN-1:0][CharW-1:0] mem [NUM_WORDS];
  logic [LenW-1:0] len_q [NUM_WORDS];
  logic [MAX_WORD_LEN-1:0][CharW-1:0] rd_row_q;
  logic [LenW-1:0] rd_len_q;
  logic slot_ok;
  logic pos_ok;
  logic [SlotW-1:0] wr_slot;
  logic [PosW-1:0] wr_pos;

  assign slot_ok = 32'(wr_i.slot) < NUM_WORDS;
  assign pos_ok = 32'(wr_i.pos) < MAX_WORD_LEN;
  assign wr_slot = SlotW'(wr_i.slot);
  assign wr_pos = PosW'(wr_i.pos);

  always_ff @(posedge clk_i) begin
    if (wr_i.wr_char && slot_ok && pos_ok) begin
      mem[wr_slot][wr_pos] <= wr_i.ch;
    end
    rd_row_q <= mem[rd_addr_i];
    rd_len_q <= len_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        len_q[i] <= '0;
      end
    end else if (wr_i.wr_len && slot_ok) begin
      len_q[wr_slot] <= wr_i.len;
    end
  end

  assign rd_row_o = rd_row_q;
  assign rd_len_o = rd_len_q;

endmodule

[hw/rtl/wbs_slot_cmp.sv]
`timescale 1ns / 1ps

// Shared compare unit: does one dictionary row, of the given length, equal the
// newest characters, with the point before it reachable?
module wbs_slot_cmp import wbs_pkg::*; #(
  parameter int MAX_WORD_LEN = 16,
  localparam int RecW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1,
  localparam int WinW = $clog2(MAX_WORD_LEN + 1)
) (
  input  logic [MAX_WORD_LEN-1:0][CharW-1:0] row_i,
  input  logic [LenW-1:0]                    len_i,
  input  logic [MAX_WORD_LEN-1:0][CharW-1:0] recent_i,
  input  logic [MAX_WORD_LEN:0]              window_i,
  output logic                               match_o
);

  logic len_ok;
  logic reach;
  logic [LenW-1:0] len_m1;
  logic [MAX_WORD_LEN-1:0] byte_ok;

  assign len_ok = (len_i != '0) && (32'(len_i) <= MAX_WORD_LEN);
  assign len_m1 = len_i - LenW'(1);
  assign reach = len_ok && window_i[WinW'(len_m1)];

  // word position p lines up with the character len-1-p back from the newest
  always_comb begin
    for (int p = 0; p < MAX_WORD_LEN; p++) begin
      if (32'(len_i) <= p) begin
        byte_ok[p] = 1'b1;
      end else begin
        byte_ok[p] = row_i[p] == recent_i[RecW'(len_m1 - LenW'(p))];
      end
    end
  end

  assign match_o = reach && (&byte_ok);

endmodule

[hw/rtl/word_break_segmenter.sv]
`timescale 1ns / 1ps

// Channel  Dir  tdata (low bit up)                               tlast
// s_axis   in   func[1:0] word_slot[5:2] char_pos[9:6]           end_of_text
//               char_value[17:10] word_length[22:18]
// m_axis   out  segmentable[0]                                   last
//
// Dictionary words leave the block idle, so they can go in back to back. After a
// text character is accepted, one registered row read per slot goes through the
// shared compare unit, then a drain state and a hand-off state pass the result on.
// Reset clears slot lengths, the recent characters and the reachable window;
// dictionary characters are not cleared. A stalled result holds the block in
// its hand-off state; the input side stays open only while idle.
module word_break_segmenter import wbs_pkg::*; #(
  parameter int NUM_WORDS = 16,
  parameter int MAX_WORD_LEN = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // func, word_slot, char_pos, char_value, word_length, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // segmentable, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast
);

  localparam int SlotW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_q, state_d;
  logic [SlotW-1:0] cnt_q, cnt_d;
  logic cmp_vld_q;
  logic hit_q, hit_d;
  logic eot_q, eot_d;
  logic [MAX_WORD_LEN-1:0][CharW-1:0] recent_q, recent_d;
  logic [MAX_WORD_LEN:0] window_q, window_d;
  logic out_vld_q, out_vld_d;
  logic out_seg_q, out_seg_d;
  logic out_last_q, out_last_d;

  logic in_acc;
  logic [FuncW-1:0] in_func;
  logic text_acc;
  logic emit_go;
  logic match;
  wbs_wr_t wr;
  logic [MAX_WORD_LEN-1:0][CharW-1:0] rd_row;
  logic [LenW-1:0] rd_len;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_func = s_axis_tdata[1:0];
  assign text_acc = in_acc && (in_func == FUNC_TEXT);
  assign emit_go = (state_q == ST_EMIT) && (!out_vld_q || m_axis_tready);

  always_comb begin
    wr.wr_char = in_acc && (in_func == FUNC_WR_CHAR);
    wr.wr_len = in_acc && (in_func == FUNC_WR_LEN);
    wr.slot = s_axis_tdata[5:2];
    wr.pos = s_axis_tdata[9:6];
    wr.ch = s_axis_tdata[17:10];
    wr.len = s_axis_tdata[22:18];
  end

  wbs_dict #(
    .NUM_WORDS(NUM_WORDS),
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_dict (
    .clk_i,
    .rst_ni,
    .wr_i(wr),
    .rd_addr_i(cnt_q),
    .rd_row_o(rd_row),
    .rd_len_o(rd_len)
  );

  wbs_slot_cmp #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_cmp (
    .row_i(rd_row),
    .len_i(rd_len),
    .recent_i(recent_q),
    .window_i(window_q),
    .match_o(match)
  );

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    hit_d = hit_q;
    eot_d = eot_q;
    recent_d = recent_q;
    window_d = window_q;

    if (cmp_vld_q && match) begin
      hit_d = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (text_acc) begin
          state_d = ST_SCAN;
          cnt_d = '0;
          hit_d = 1'b0;
          eot_d = s_axis_tlast;
          recent_d[0] = s_axis_tdata[17:10];
          for (int i = 1; i < MAX_WORD_LEN; i++) begin
            recent_d[i] = recent_q[i-1];
          end
        end
      end
      ST_SCAN: begin
        if (cnt_q == SlotW'(NUM_WORDS - 1)) begin
          state_d = ST_LAST;
        end else begin
          cnt_d = cnt_q + SlotW'(1);
        end
      end
      ST_LAST: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_d = ST_IDLE;
          if (eot_q) begin
            recent_d = '0;
            window_d = (MAX_WORD_LEN + 1)'(1);
          end else begin
            window_d = {window_q[MAX_WORD_LEN-1:0], hit_q};
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_seg_d = out_seg_q;
    out_last_d = out_last_q;
    if (emit_go) begin
      out_vld_d = 1'b1;
      out_seg_d = hit_q;
      out_last_d = eot_q;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      cmp_vld_q <= 1'b0;
      hit_q <= 1'b0;
      eot_q <= 1'b0;
      recent_q <= '0;
      window_q <= (MAX_WORD_LEN + 1)'(1);
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      cmp_vld_q <= (state_q == ST_SCAN);
      hit_q <= hit_d;
      eot_q <= eot_d;
      recent_q <= recent_d;
      window_q <= window_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_seg_q <= out_seg_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = {{(OutDataW - 1){1'b0}}, out_seg_q};
  assign m_axis_tlast = out_last_q;

endmodule

[tb/tb_word_break_segmenter.sv]
`timescale 1ns / 1ps

module tb_word_break_segmenter import wbs_pkg::*;;

  localparam int NUM_WORDS = 16;
  localparam int MAX_LEN = 16;
  localparam logic [FuncW-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [CharW-1:0] CH_A = 8'h61;
  localparam logic [CharW-1:0] CH_B = 8'h62;

  typedef struct packed {
    logic [FuncW-1:0]      func;
    logic [SlotFieldW-1:0] slot;
    logic [PosFieldW-1:0]  pos;
    logic [CharW-1:0]      ch;
    logic [LenW-1:0]       len;
    logic                  eot;
  } in_word_t;

  typedef struct packed {
    logic seg;
    logic last;
  } answer_t;

  // Tracks the dictionary and the split window, predicts one answer per text char
  class break_tracker;
    logic [CharW-1:0] dict_chars [NUM_WORDS][MAX_LEN];
    logic [LenW-1:0]  dict_lens [NUM_WORDS];
    logic [CharW-1:0] recent [MAX_LEN];
    logic [MAX_LEN:0] reach;
    answer_t          due_answers[$];
    int               errors;

    function void clear_text();
      foreach (recent[k]) recent[k] = '0;
      reach = (MAX_LEN + 1)'(1);
    endfunction

    function void power_on();
      foreach (dict_lens[s]) dict_lens[s] = '0;
      clear_text();
      due_answers.delete();
      errors = 0;
    endfunction

    function void complain(string what, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= 10) $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    endfunction

    function void note_word(in_word_t w);
      logic [MAX_LEN:0] prior;
      logic hit;
      logic same;
      int span;
      case (w.func)
        FUNC_WR_CHAR: begin
          if (w.slot < NUM_WORDS && w.pos < MAX_LEN) dict_chars[w.slot][w.pos] = w.ch;
        end
        FUNC_WR_LEN: begin
          if (w.slot < NUM_WORDS) dict_lens[w.slot] = w.len;
        end
        FUNC_TEXT: begin
          prior = reach;
          hit = 1'b0;
          for (int k = MAX_LEN - 1; k > 0; k--) recent[k] = recent[k-1];
          recent[0] = w.ch;
          for (int s = 0; s < NUM_WORDS; s++) begin
            span = int'(dict_lens[s]);
            // a word only counts if the split point just before it is reachable
            if (span == 0 || span > MAX_LEN || !prior[span-1]) continue;
            same = 1'b1;
            for (int p = 0; p < span; p++)
              if (recent[span-1-p] !== dict_chars[s][p]) same = 1'b0;
            if (same) hit = 1'b1;
          end
          reach = {prior[MAX_LEN-1:0], hit};
          due_answers.push_back('{seg: hit, last: w.eot});
          if (w.eot) clear_text();
        end
        default: ;
      endcase
    endfunction

    function void check_answer(logic [OutDataW-1:0] data, logic last);
      answer_t want;
      if (due_answers.size() == 0) begin
        complain("answer with none due", 8'hxx, data);
        return;
      end
      want = due_answers.pop_front();
      if (data !== {{(OutDataW-1){1'b0}}, want.seg}) complain("segmentable", 8'(want.seg), data);
      if (last !== want.last) complain("last", 8'(want.last), 8'(last));
    endfunction

    function void close_out();
      while (due_answers.size() != 0) begin
        complain("answer never delivered", 8'(due_answers[0].seg), 8'hxx);
        void'(due_answers.pop_front());
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  break_tracker     board;
  bit               steady_src;
  bit               steady_sink;
  int               items_sent;
  logic [CharW-1:0] alpha [3];
  logic [CharW-1:0] word_text [NUM_WORDS][MAX_LEN];
  int               word_len [NUM_WORDS];

  word_break_segmenter #(
    .NUM_WORDS   (NUM_WORDS),
    .MAX_WORD_LEN(MAX_LEN)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 4);
    if (r < 88) return $urandom_range(5, MAX_LEN);
    if (r < 94) return 0;
    return $urandom_range(MAX_LEN + 1, 31);
  endfunction

  function automatic logic [CharW-1:0] pick_char();
    if ($urandom_range(0, 15) == 0) return CharW'($urandom_range(0, 255));
    return alpha[$urandom_range(0, 2)];
  endfunction

  function automatic in_word_t make_word(logic [FuncW-1:0] func, int slot, int pos,
                                         int ch, int len, int eot);
    in_word_t w;
    w.func = func;
    w.slot = slot[SlotFieldW-1:0];
    w.pos  = pos[PosFieldW-1:0];
    w.ch   = ch[CharW-1:0];
    w.len  = len[LenW-1:0];
    w.eot  = eot[0];
    return w;
  endfunction

  // valid stays high across back-to-back words; only gaps and drains lower it
  task automatic send_word(in_word_t w);
    int gap;
    gap = steady_src ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, w.len, w.ch, w.pos, w.slot, w.func};
    s_axis_tlast  <= w.eot;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_word(w);
    if (w.func != FUNC_UNUSED) items_sent++;
  endtask

  task automatic send_text(logic [CharW-1:0] ch, logic eot);
    send_word(make_word(FUNC_TEXT, $urandom_range(0, 15), $urandom_range(0, 15), ch,
                        $urandom_range(0, 31), eot));
  endtask

  // characters always go in before the length, so no unwritten char is ever compared
  task automatic program_slot(int slot, int len);
    logic [CharW-1:0] c;
    if (len <= MAX_LEN) begin
      for (int p = 0; p < len; p++) begin
        c = pick_char();
        word_text[slot][p] = c;
        send_word(make_word(FUNC_WR_CHAR, slot, p, c, $urandom_range(0, 31),
                            $urandom_range(0, 1)));
      end
    end
    word_len[slot] = len;
    send_word(make_word(FUNC_WR_LEN, slot, $urandom_range(0, 15), $urandom_range(0, 255),
                        len, $urandom_range(0, 1)));
  endtask

  task automatic send_junk();
    int s;
    int l;
    case ($urandom_range(0, 2))
      0: send_word(make_word(FUNC_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                             $urandom_range(0, 255), $urandom_range(0, 31),
                             $urandom_range(0, 1)));
      1: begin
        s = $urandom_range(0, NUM_WORDS - 1);
        l = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_LEN + 1, 31);
        word_len[s] = l;
        send_word(make_word(FUNC_WR_LEN, s, $urandom_range(0, 15), $urandom_range(0, 255),
                            l, $urandom_range(0, 1)));
      end
      default: program_slot($urandom_range(0, NUM_WORDS - 1), pick_len());
    endcase
  endtask

  // Mostly concatenations of current dictionary words, with some mutation
  task automatic send_string();
    logic [CharW-1:0] txt[$];
    int s;
    int n;
    bit run_on;
    if ($urandom_range(0, 9) < 7) begin
      repeat ($urandom_range(1, 4)) begin
        s = $urandom_range(0, NUM_WORDS - 1);
        if (word_len[s] >= 1 && word_len[s] <= MAX_LEN)
          for (int p = 0; p < word_len[s]; p++) txt.push_back(word_text[s][p]);
        else
          txt.push_back(pick_char());
      end
    end else begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
      repeat (n) txt.push_back(pick_char());
    end
    foreach (txt[i]) if ($urandom_range(0, 19) == 0) txt[i] = pick_char();
    run_on = ($urandom_range(0, 9) == 0);
    foreach (txt[i]) begin
      if ($urandom_range(0, 24) == 0) send_junk();
      send_text(txt[i], (i == txt.size() - 1) && !run_on);
    end
  endtask

  task automatic wait_answers_in();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.due_answers.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int phase;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    rst_ni        = 1'b0;
    steady_src    = 1'b0;
    steady_sink   = 1'b0;
    items_sent    = 0;
    foreach (word_len[s]) word_len[s] = 0;
    foreach (alpha[k]) alpha[k] = CharW'(CH_A + k);
    board = new();
    board.power_on();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty dictionary, then unused func with every field at its top value
    send_text(CH_A, 1'b1);
    send_word(make_word(FUNC_UNUSED, 15, 15, 255, 31, 1));
    // slot 0 = "ab", slot 15 = single zero byte, top slot/position/byte written
    send_word(make_word(FUNC_WR_CHAR, 0, 0, CH_A, 0, 0));
    send_word(make_word(FUNC_WR_CHAR, 0, 1, CH_B, 0, 0));
    send_word(make_word(FUNC_WR_LEN, 0, 0, 0, 2, 0));
    send_word(make_word(FUNC_WR_CHAR, 15, 0, 0, 0, 0));
    send_word(make_word(FUNC_WR_CHAR, 15, 15, 255, 0, 1));
    send_word(make_word(FUNC_WR_LEN, 15, 0, 0, 1, 0));
    // lengths beyond the window never match
    send_word(make_word(FUNC_WR_LEN, 1, 0, 0, 31, 0));
    send_word(make_word(FUNC_WR_LEN, 2, 0, 0, MAX_LEN + 1, 0));
    send_text(CH_A, 1'b0);
    send_text(CH_B, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(CH_A, 1'b0);
    // disabling a slot mid-text hits the very next char
    send_word(make_word(FUNC_WR_LEN, 0, 0, 0, 0, 0));
    send_text(CH_B, 1'b1);
    send_word(make_word(FUNC_WR_LEN, 0, 0, 0, 2, 0));
    send_text(CH_B, 1'b0);
    send_text(CH_A, 1'b0);
    send_text(CH_B, 1'b1);
    send_text(CH_A, 1'b0);
    send_text(CH_B, 1'b1);

    phase = 0;
    while (items_sent < 1400) begin
      steady_src  = ($urandom_range(0, 3) == 0);
      steady_sink = ($urandom_range(0, 3) == 0);
      alpha[0] = CharW'($urandom_range(0, 255));
      alpha[1] = CharW'($urandom_range(0, 255));
      alpha[2] = ($urandom_range(0, 3) == 0) ? alpha[0] : 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, 5)) program_slot($urandom_range(0, NUM_WORDS - 1), pick_len());
      repeat ($urandom_range(1, 6)) send_string();
      if (phase == 0 || $urandom_range(0, 3) == 0) wait_answers_in();
      phase++;
    end

    wait_answers_in();
    repeat (4 * NUM_WORDS) @(posedge clk_i);
    board.close_out();
    if (board.errors == 0) begin
      $display("tb_word_break_segmenter: clean");
    end else begin
      $display("tb_word_break_segmenter: errors");
    end
    $finish;
  end

  initial begin : sink_side
    int stall;
    int run;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady_sink ? 0 : pick_gap();
      if (stall > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      run = $urandom_range(1, 12);
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      repeat (run - 1) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_answer(m_axis_tdata, m_axis_tlast);
  end

  initial begin
    #30_000_000;
    $display("tb_word_break_segmenter: errors");
    $finish;
  end

endmodule
